FILE: rtl/rhc_pkg.sv
// Shared constants, types and a helper function for the RGB/HSV color converter.
// Used by every module of the converter; depends on nothing.
package rhc_pkg;

  localparam int C = 16;
  localparam int PORT_W = 16;
  localparam int DW = C + 3;

  localparam logic [1:0] MODE_RGB2HSV  = 2'd0;
  localparam logic [1:0] MODE_HSV2RGB  = 2'd1;
  localparam logic [1:0] MODE_NEGATIVE = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [C-1:0] CH_MAX = {C{1'b1}};
  localparam logic [2*C-1:0] FULL_SCALE = {CH_MAX, {C{1'b0}}};

  typedef logic [C-1:0] chan_t;

  typedef struct packed {
    logic [1:0] mode;
    chan_t      a;
    chan_t      b;
    chan_t      c;
    chan_t      mx;
    logic       neg;
    logic       grey;
  } side_t;

  // Floor of x divided by 2^C - 1, for results that fit in C bits.
  function automatic chan_t div_max(input logic [2*C-1:0] x);
    logic [C:0] s;
    logic [C:0] a;
    s = {1'b0, x[2*C-1:C]} + {1'b0, x[C-1:0]};
    a = {1'b0, x[2*C-1:C]};
    if (s >= {CH_MAX, 1'b0}) begin
      a = a + (C+1)'(2);
    end else if (s >= {1'b0, CH_MAX}) begin
      a = a + (C+1)'(1);
    end
    return a[C-1:0];
  endfunction

endpackage

FILE: rtl/rhc_front.sv
// Front end of the converter: maximum, minimum, largest channel and the two division operands.
// Two register stages; depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [1:0]    mode_i,
  input  chan_t         a_i,
  input  chan_t         b_i,
  input  chan_t         c_i,
  output logic [DW-1:0] hue_hi_o,
  output logic [DW-1:0] hue_den_o,
  output logic [DW-1:0] sat_hi_o,
  output chan_t         sat_lo_o,
  output logic [DW-1:0] sat_den_o,
  output side_t         side_o
);

  logic [1:0] mode_r;
  chan_t      r_r, g_r, b_r, mx_r, mn_r;
  logic       rmax_r, gmax_r;
  chan_t      mx_nxt, mn_nxt;

  logic [DW-1:0]  hue_hi_r, hue_den_r, sat_hi_r, sat_den_r;
  chan_t          sat_lo_r;
  side_t          side_r;
  chan_t          d;
  logic [DW-1:0]  dx, num;
  logic [2*C-1:0] sprod;
  logic           neg;

  always_comb begin
    mx_nxt = a_i;
    if (b_i > mx_nxt) mx_nxt = b_i;
    if (c_i > mx_nxt) mx_nxt = c_i;
    mn_nxt = a_i;
    if (b_i < mn_nxt) mn_nxt = b_i;
    if (c_i < mn_nxt) mn_nxt = c_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= mode_i;
      r_r    <= a_i;
      g_r    <= b_i;
      b_r    <= c_i;
      mx_r   <= mx_nxt;
      mn_r   <= mn_nxt;
      rmax_r <= (a_i == mx_nxt);
      gmax_r <= (b_i == mx_nxt);
    end
  end

  always_comb begin
    d     = mx_r - mn_r;
    dx    = DW'(d);
    neg   = rmax_r && (g_r < b_r);
    sprod = {d, {C{1'b0}}} - {{C{1'b0}}, d};
    if (rmax_r) begin
      num = neg ? DW'(b_r - g_r) : DW'(g_r - b_r);
    end else if (gmax_r) begin
      num = (dx << 1) + DW'(b_r) - DW'(r_r);
    end else begin
      num = (dx << 2) + DW'(r_r) - DW'(g_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_hi_r  <= num;
      hue_den_r <= (dx << 2) + (dx << 1);
      sat_hi_r  <= DW'(sprod[2*C-1:C]);
      sat_lo_r  <= sprod[C-1:0];
      sat_den_r <= DW'(mx_r);
      side_r    <= '{mode: mode_r, a: r_r, b: g_r, c: b_r, mx: mx_r,
                     neg: neg, grey: (d == '0)};
    end
  end

  assign hue_hi_o  = hue_hi_r;
  assign hue_den_o = hue_den_r;
  assign sat_hi_o  = sat_hi_r;
  assign sat_lo_o  = sat_lo_r;
  assign sat_den_o = sat_den_r;
  assign side_o    = side_r;

endmodule

FILE: rtl/rhc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The high dividend part must be below the divisor; depends on rhc_pkg.
module rhc_div import rhc_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] hi_i,
  input  chan_t         lo_i,
  input  logic [DW-1:0] den_i,
  output chan_t         quo_o
);

  logic [DW-1:0] rem_r [C];
  logic [DW-1:0] rem_nxt [C];
  logic [DW-1:0] den_r [C];
  logic [DW-1:0] din [C];
  logic [DW-1:0] rin [C];
  chan_t         lo_r [C];
  chan_t         lo_nxt [C];
  chan_t         lin [C];
  chan_t         quo_r [C];
  chan_t         quo_nxt [C];
  chan_t         qin [C];
  logic [DW:0]   trial [C];
  logic [DW:0]   diff [C];

  always_comb begin
    rin[0] = hi_i;
    lin[0] = lo_i;
    qin[0] = '0;
    din[0] = den_i;
    for (int k = 1; k < C; k++) begin
      rin[k] = rem_r[k-1];
      lin[k] = lo_r[k-1];
      qin[k] = quo_r[k-1];
      din[k] = den_r[k-1];
    end
    for (int k = 0; k < C; k++) begin
      trial[k]  = {rin[k], lin[k][C-1]};
      diff[k]   = trial[k] - {1'b0, din[k]};
      lo_nxt[k] = {lin[k][C-2:0], 1'b0};
      if (trial[k] >= {1'b0, din[k]}) begin
        rem_nxt[k] = diff[k][DW-1:0];
        quo_nxt[k] = {qin[k][C-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][DW-1:0];
        quo_nxt[k] = {qin[k][C-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < C; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= din[k];
      end
    end
  end

  assign quo_o = quo_r[C-1];

endmodule

FILE: rtl/rhc_back.sv
// Back end: hue fix-up, mode selection and the HSV to RGB conversion.
// Five register stages, the last one drives the result item; depends on rhc_pkg.
module rhc_back import rhc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  chan_t hue_q_i,
  input  chan_t sat_q_i,
  input  side_t side_i,
  output chan_t x_o,
  output chan_t y_o,
  output chan_t z_o
);

  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;

  typedef struct packed {
    chan_t h;
    chan_t s;
    chan_t v;
  } pass_t;

  // Stage 0
  chan_t hue, sat;
  pass_t p0_r;
  chan_t h0_r, s0_r, v0_r;
  logic  conv0_r;

  always_comb begin
    hue = side_i.grey ? '0 : (side_i.neg ? chan_t'(-hue_q_i) : hue_q_i);
    sat = side_i.grey ? '0 : sat_q_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= '{h: hue, s: sat, v: side_i.mx};
      conv0_r <= (side_i.mode == MODE_HSV2RGB) || (side_i.mode == MODE_NEGATIVE);
      if (side_i.mode == MODE_HSV2RGB) begin
        h0_r <= side_i.a;
        s0_r <= side_i.b;
        v0_r <= side_i.c;
      end else begin
        h0_r <= hue;
        s0_r <= sat;
        v0_r <= CH_MAX - side_i.mx;
      end
    end
  end

  // Stage 1
  logic [DW-1:0]  x6;
  logic [C:0]     fc;
  pass_t          p1_r;
  logic           conv1_r, vz1_r, sz1_r;
  chan_t          v1_r, mp1_r;
  logic [2:0]     sec1_r;
  logic [2*C-1:0] ma1_r, mb1_r;

  always_comb begin
    x6 = (DW'(h0_r) << 2) + (DW'(h0_r) << 1);
    fc = {1'b1, {C{1'b0}}} - {1'b0, x6[C-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p0_r;
      conv1_r <= conv0_r;
      vz1_r   <= (v0_r == '0);
      sz1_r   <= (s0_r == '0);
      v1_r    <= v0_r;
      mp1_r   <= CH_MAX - s0_r;
      sec1_r  <= x6[DW-1:C];
      ma1_r   <= s0_r * x6[C-1:0];
      mb1_r   <= (2*C)'(s0_r * fc);
    end
  end

  // Stage 2
  logic [2*C-1:0] eq, et;
  pass_t          p2_r;
  logic           conv2_r, vz2_r, sz2_r;
  chan_t          v2_r;
  logic [2:0]     sec2_r;
  logic [2*C-1:0] pp2_r;
  logic [3*C-1:0] pq2_r, pt2_r;

  always_comb begin
    eq = FULL_SCALE - ma1_r;
    et = FULL_SCALE - mb1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r    <= p1_r;
      conv2_r <= conv1_r;
      vz2_r   <= vz1_r;
      sz2_r   <= sz1_r;
      v2_r    <= v1_r;
      sec2_r  <= sec1_r;
      pp2_r   <= v1_r * mp1_r;
      pq2_r   <= v1_r * eq;
      pt2_r   <= v1_r * et;
    end
  end

  // Stage 3
  pass_t      p3_r;
  logic       conv3_r, vz3_r, sz3_r;
  chan_t      v3_r, pv3_r, qv3_r, tv3_r;
  logic [2:0] sec3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r    <= p2_r;
      conv3_r <= conv2_r;
      vz3_r   <= vz2_r;
      sz3_r   <= sz2_r;
      v3_r    <= v2_r;
      sec3_r  <= sec2_r;
      pv3_r   <= div_max(pp2_r);
      qv3_r   <= div_max(pq2_r[3*C-1:C]);
      tv3_r   <= div_max(pt2_r[3*C-1:C]);
    end
  end

  // Stage 4
  chan_t x_nxt, y_nxt, z_nxt;
  chan_t x_r, y_r, z_r;

  always_comb begin
    if (!conv3_r) begin
      x_nxt = p3_r.h;
      y_nxt = p3_r.s;
      z_nxt = p3_r.v;
    end else if (vz3_r) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end else if (sz3_r) begin
      x_nxt = v3_r;
      y_nxt = v3_r;
      z_nxt = v3_r;
    end else begin
      case (sec3_r)
        SEC_RY: begin x_nxt = v3_r;  y_nxt = tv3_r; z_nxt = pv3_r; end
        SEC_YG: begin x_nxt = qv3_r; y_nxt = v3_r;  z_nxt = pv3_r; end
        SEC_GC: begin x_nxt = pv3_r; y_nxt = v3_r;  z_nxt = tv3_r; end
        SEC_CB: begin x_nxt = pv3_r; y_nxt = qv3_r; z_nxt = v3_r;  end
        SEC_BM: begin x_nxt = tv3_r; y_nxt = pv3_r; z_nxt = v3_r;  end
        default: begin x_nxt = v3_r; y_nxt = pv3_r; z_nxt = qv3_r; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

FILE: rtl/rgb_hsv_color_converter.sv
// Top level of the RGB/HSV color converter: handshake, mode register and pipeline.
// The pipeline has two front stages, one stage per quotient bit in the dividers and five
// back stages. Throughput is one item per cycle unless a stalled output item holds it.
// Reset clears the mode register to RGB to HSV and empties the pipeline.
// Depends on rhc_pkg, rhc_front, rhc_div and rhc_back.
module rgb_hsv_color_converter import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PORT_W-1:0] in_chan_a,
  input  logic [PORT_W-1:0] in_chan_b,
  input  logic [PORT_W-1:0] in_chan_c,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PORT_W-1:0] out_a,
  output logic [PORT_W-1:0] out_b,
  output logic [PORT_W-1:0] out_c
);

  localparam int LAT = C + 7;

  logic [1:0]    mode_r, mode_eff;
  logic          en;
  logic [LAT-1:0] vld_r;

  logic [DW-1:0] hue_hi, hue_den, sat_hi, sat_den;
  chan_t         sat_lo, hue_q, sat_q, x, y, z;
  side_t         side_f;
  side_t         side_r [C];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGB2HSV;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign mode_eff = (mode_r == MODE_UNUSED) ? MODE_RGB2HSV : mode_r;
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  rhc_front u_front (
    .clk       (clk),
    .en        (en),
    .mode_i    (mode_eff),
    .a_i       (in_chan_a[C-1:0]),
    .b_i       (in_chan_b[C-1:0]),
    .c_i       (in_chan_c[C-1:0]),
    .hue_hi_o  (hue_hi),
    .hue_den_o (hue_den),
    .sat_hi_o  (sat_hi),
    .sat_lo_o  (sat_lo),
    .sat_den_o (sat_den),
    .side_o    (side_f)
  );

  rhc_div u_div_hue (
    .clk   (clk),
    .en    (en),
    .hi_i  (hue_hi),
    .lo_i  ('0),
    .den_i (hue_den),
    .quo_o (hue_q)
  );

  rhc_div u_div_sat (
    .clk   (clk),
    .en    (en),
    .hi_i  (sat_hi),
    .lo_i  (sat_lo),
    .den_i (sat_den),
    .quo_o (sat_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_f;
      for (int k = 1; k < C; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  rhc_back u_back (
    .clk     (clk),
    .en      (en),
    .hue_q_i (hue_q),
    .sat_q_i (sat_q),
    .side_i  (side_r[C-1]),
    .x_o     (x),
    .y_o     (y),
    .z_o     (z)
  );

  assign out_valid = vld_r[LAT-1];
  assign out_a     = PORT_W'(x);
  assign out_b     = PORT_W'(y);
  assign out_c     = PORT_W'(z);

endmodule

FILE: test/rgb_hsv_color_converter_tb.sv
// Self-checking testbench for the RGB/HSV color converter in all of its modes.
// A directed table and random pixels are checked against an in-bench color model.
// Depends on rhc_pkg and the rgb_hsv_color_converter RTL.
module rgb_hsv_color_converter_tb;
  import rhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CMAX = 65535;
  localparam longint TURN = 65536;
  localparam int LATENCY = 23;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } pixel_t;

  typedef struct {
    logic        we;
    logic [1:0]  mode;
    pixel_t      px;
    logic        known;
    pixel_t      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_chan_a = '0, in_chan_b = '0, in_chan_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_a, out_b, out_c;

  logic [1:0] model_mode;
  pixel_t pending_px[$];
  int errors = 0;
  int table_errors = 0;
  int checked = 0;
  int cycles = 0;
  int out_wait_max = 0;

  rgb_hsv_color_converter uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_chan_a(in_chan_a),
    .in_chan_b(in_chan_b), .in_chan_c(in_chan_c), .out_valid(out_valid),
    .out_stall(out_stall), .out_a(out_a), .out_b(out_b), .out_c(out_c)
  );

  always #5 clk = ~clk;

  function automatic pixel_t to_hsv(longint r, longint g, longint b);
    longint mx, mn, d, hue, sat;
    pixel_t o;
    mx = r; mn = r; hue = 0; sat = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (mx != 0) sat = (d * CMAX) / mx;
    if (sat != 0) begin
      if (r == mx) begin
        if (g >= b) hue = ((g - b) * TURN) / (6 * d);
        else hue = TURN - ((b - g) * TURN) / (6 * d);
      end else if (g == mx) begin
        hue = ((2 * d + b - r) * TURN) / (6 * d);
      end else begin
        hue = ((4 * d + r - g) * TURN) / (6 * d);
      end
      hue = hue % TURN;
    end
    o.a = hue[15:0]; o.b = sat[15:0]; o.c = mx[15:0];
    return o;
  endfunction

  function automatic pixel_t to_rgb(longint h, longint s, longint v);
    longint x, sec, f, p, q, t, full;
    pixel_t o;
    if (v == 0) begin
      o.a = '0; o.b = '0; o.c = '0;
    end else if (s == 0) begin
      o.a = v[15:0]; o.b = v[15:0]; o.c = v[15:0];
    end else begin
      x = 6 * h;
      sec = x / TURN;
      f = x % TURN;
      full = CMAX * TURN;
      p = (v * (CMAX - s)) / CMAX;
      q = (v * (full - s * f)) / full;
      t = (v * (full - s * (TURN - f))) / full;
      case (sec)
        0: begin o.a = v[15:0]; o.b = t[15:0]; o.c = p[15:0]; end
        1: begin o.a = q[15:0]; o.b = v[15:0]; o.c = p[15:0]; end
        2: begin o.a = p[15:0]; o.b = v[15:0]; o.c = t[15:0]; end
        3: begin o.a = p[15:0]; o.b = q[15:0]; o.c = v[15:0]; end
        4: begin o.a = t[15:0]; o.b = p[15:0]; o.c = v[15:0]; end
        default: begin o.a = v[15:0]; o.b = p[15:0]; o.c = q[15:0]; end
      endcase
    end
    return o;
  endfunction

  function automatic pixel_t convert_pixel(logic [1:0] md, pixel_t px);
    pixel_t hsv;
    if (md == MODE_HSV2RGB) return to_rgb(px.a, px.b, px.c);
    hsv = to_hsv(px.a, px.b, px.c);
    if (md == MODE_NEGATIVE) return to_rgb(hsv.a, hsv.b, CMAX - hsv.c);
    return hsv;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall)
      pending_px.push_back(convert_pixel(model_mode, '{in_chan_a, in_chan_b, in_chan_c}));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected item %h %h %h", $time, out_a, out_b, out_c);
        errors <= errors + 1;
      end else begin
        pixel_t e;
        e = pending_px.pop_front();
        checked <= checked + 1;
        if (e.a !== out_a || e.b !== out_b || e.c !== out_c) begin
          $display("%0t: mismatch expected %h %h %h actual %h %h %h", $time,
                   e.a, e.b, e.c, out_a, out_b, out_c);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_hsv_color_converter regression: fail");
      $finish;
    end
  end

  // The receiver stalls for a random stretch, or not at all, between accepted items.
  initial begin : receiver
    int w;
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall) begin
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, out_wait_max);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic set_mode(logic [1:0] md);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= md;
    model_mode = md;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Leaves the valid high after the accepting edge; drain, or a gap in the next call, drops it.
  task automatic send_pixel(pixel_t px, int gap_max);
    int g;
    g = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, gap_max);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_chan_a <= px.a; in_chan_b <= px.b; in_chan_c <= px.c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    pixel_t px, exp_px;
    int n;
    model_mode = MODE_RGB2HSV;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    // Directed part: grey, primaries, extremes, hue wrap, HSV to RGB, negative and the unused mode.
    dir_rows = '{
      '{0, 0, '{16'h0000, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'h0000, 16'h0000}},
      '{0, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{16'h0000, 16'h0000, 16'hFFFF}},
      '{0, 0, '{16'hFFFF, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'hFFFF, 16'hFFFF}},
      '{0, 0, '{16'h0000, 16'hFFFF, 16'h0000}, 0, '{0, 0, 0}},
      '{0, 0, '{16'h0000, 16'h0000, 16'hFFFF}, 0, '{0, 0, 0}},
      '{0, 0, '{16'hFFFF, 16'h0000, 16'h0001}, 0, '{0, 0, 0}},
      '{0, 0, '{16'h8000, 16'h8000, 16'h1234}, 0, '{0, 0, 0}},
      '{1, 3, '{16'hFFFF, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'hFFFF, 16'hFFFF}},
      '{0, 3, '{16'h1234, 16'h5678, 16'h9ABC}, 0, '{0, 0, 0}},
      '{1, 1, '{16'h1234, 16'hFFFF, 16'h0000}, 1, '{16'h0000, 16'h0000, 16'h0000}},
      '{0, 1, '{16'h1234, 16'h0000, 16'h7777}, 1, '{16'h7777, 16'h7777, 16'h7777}},
      '{0, 1, '{16'h0000, 16'hFFFF, 16'hFFFF}, 1, '{16'hFFFF, 16'h0000, 16'h0000}},
      '{0, 1, '{16'h2AAB, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{0, 1, '{16'h5555, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{0, 1, '{16'h8000, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{0, 1, '{16'hAAAA, 16'h8000, 16'hFFFF}, 0, '{0, 0, 0}},
      '{0, 1, '{16'hD555, 16'hFFFF, 16'h8000}, 0, '{0, 0, 0}},
      '{0, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{1, 2, '{16'h0000, 16'h0000, 16'h0000}, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
      '{0, 2, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{16'h0000, 16'h0000, 16'h0000}},
      '{0, 2, '{16'hFFFF, 16'h0000, 16'h0000}, 0, '{0, 0, 0}},
      '{0, 2, '{16'h4000, 16'h2000, 16'h1000}, 0, '{0, 0, 0}}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].we) begin
        drain();
        set_mode(dir_rows[i].mode);
      end
      if (dir_rows[i].known) begin
        exp_px = convert_pixel(model_mode, dir_rows[i].px);
        if (exp_px != dir_rows[i].res) begin
          $display("%0t: table row %0d expected %h %h %h actual %h %h %h", $time, i,
                   dir_rows[i].res.a, dir_rows[i].res.b, dir_rows[i].res.c,
                   exp_px.a, exp_px.b, exp_px.c);
          table_errors++;
        end
      end
      send_pixel(dir_rows[i].px, 2);
    end
    // Random part: phases across all modes, some with no idling at all.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      set_mode(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
      out_wait_max = (ph % 3 == 0) ? 0 : 16;
      n = 120;
      repeat (n) begin
        px.a = rand_chan(); px.b = rand_chan(); px.c = rand_chan();
        send_pixel(px, (ph % 3 == 0) ? 0 : 16);
      end
    end
    drain();
    $display("Checked %0d items over directed and random phases in all four mode codes.",
             checked);
    if (errors == 0 && table_errors == 0) begin
      $display("rgb_hsv_color_converter regression: pass");
    end else begin
      $display("rgb_hsv_color_converter regression: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div.sv
rtl/rhc_back.sv
rtl/rgb_hsv_color_converter.sv
test/rgb_hsv_color_converter_tb.sv
